FILE: rtl/core/cpd_pkg.sv
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, register indexes and reset values of the call duration
// profiler stack.
// ----------------------------------------------------------------------------
package cpd_pkg;

   localparam int CPD_STACK_DEPTH = 64;

   localparam int CLASS_W    = 64;
   localparam int SEL_W      = 64;
   localparam int TIME_W     = 30;
   localparam int DEPTH_W    = 6;
   localparam int COST_W     = 64;
   localparam int COUNT_W    = 32;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 30;

   localparam logic [CSR_ADDR_W-1:0] REG_TRACE_ENABLE = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_DEPTH_LIMIT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_MIN_COST     = 2'd2;

   localparam logic               RST_TRACE_ENABLE = 1'b1;
   localparam logic [DEPTH_W-1:0] RST_DEPTH_LIMIT  = 6'd3;
   localparam logic [TIME_W-1:0]  RST_MIN_COST     = 30'd1000;

   localparam logic KIND_ENTER  = 1'b0;
   localparam logic KIND_RETURN = 1'b1;

   typedef struct packed {
      logic [CLASS_W-1:0] class_id;
      logic [SEL_W-1:0]   selector_id;
      logic [TIME_W-1:0]  start;
   } frame_type;

   typedef struct packed {
      logic [CLASS_W-1:0] rec_class;
      logic [SEL_W-1:0]   rec_selector;
      logic [DEPTH_W-1:0] rec_depth;
      logic [COST_W-1:0]  rec_cost;
   } record_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctrl_type;

endpackage

FILE: rtl/core/cpd_if.sv
// ----------------------------------------------------------------------------
// cpd_if
// Valid/ready channels of the call duration profiler stack: trace events,
// slow call records and register writes.
// ----------------------------------------------------------------------------
interface cpd_req_if;
   import cpd_pkg::*;
   logic               valid;
   logic               ready;
   logic               kind;
   logic               on_main_thread;
   logic [CLASS_W-1:0] class_id;
   logic [SEL_W-1:0]   selector_id;
   logic [TIME_W-1:0]  timestamp;

   modport source (output valid, kind, on_main_thread, class_id, selector_id, timestamp,
                   input ready);
   modport sink   (input valid, kind, on_main_thread, class_id, selector_id, timestamp,
                   output ready);
endinterface

interface cpd_rsp_if;
   import cpd_pkg::*;
   logic               valid;
   logic               ready;
   logic [CLASS_W-1:0] rec_class;
   logic [SEL_W-1:0]   rec_selector;
   logic [DEPTH_W-1:0] rec_depth;
   logic [COST_W-1:0]  rec_cost;

   modport source (output valid, rec_class, rec_selector, rec_depth, rec_cost,
                   input ready);
   modport sink   (input valid, rec_class, rec_selector, rec_depth, rec_cost,
                   output ready);
endinterface

interface cpd_csr_if;
   import cpd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_ADDR_W-1:0] index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/cpd_cell.sv
// ----------------------------------------------------------------------------
// cpd_cell
// One frame slot of the shifting call stack. A push takes the frame of the
// neighbor above, a pop takes the frame of the neighbor below.
// ----------------------------------------------------------------------------
module cpd_cell
   import cpd_pkg::*;
(
   input  logic           clock,
   input  stack_ctrl_type ctrl,
   input  frame_type      from_above,
   input  frame_type      from_below,
   output frame_type      frame
);

   frame_type frame_ff;
   frame_type frame_in;

   always_comb begin
      frame_in = frame_ff;
      if (ctrl.push) begin
         frame_in = from_above;
      end else if (ctrl.pop) begin
         frame_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame = frame_ff;

endmodule

FILE: rtl/core/cpd_rsp_queue.sv
// ----------------------------------------------------------------------------
// cpd_rsp_queue
// Two-entry record queue in front of the result channel, so that events keep
// flowing while one record waits to be taken.
// ----------------------------------------------------------------------------
module cpd_rsp_queue
   import cpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  record_type push_data,
   output logic       not_full,
   cpd_rsp_if.source  rsp
);

   record_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   record_type head;

   assign pop      = rsp.valid && rsp.ready;
   assign not_full = (count_ff != 2'd2);
   assign head     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp.valid        = (count_ff != 2'd0);
   assign rsp.rec_class    = head.rec_class;
   assign rsp.rec_selector = head.rec_selector;
   assign rsp.rec_depth    = head.rec_depth;
   assign rsp.rec_cost     = head.rec_cost;

endmodule

FILE: rtl/core/call_duration_profiler_stack.sv
// ----------------------------------------------------------------------------
// call_duration_profiler_stack
// Tracks nested call enter and return events of the main thread on a chain
// of frame cells and reports calls that lasted at least min_cost.
// ----------------------------------------------------------------------------
// Throughput: one event per cycle while the queue is not full; an event that
// pushes or pops updates the cell chain in the cycle it is accepted. A record
// is registered in the queue as its return event is accepted. The two-entry
// record queue sets the stall point: events are held off only while both
// entries are occupied. Reset clears the stack depth, the ignored-call count
// and the queue and loads the register defaults; frame cells are not cleared.
module call_duration_profiler_stack
   import cpd_pkg::*;
#(
   parameter int STACK_DEPTH = CPD_STACK_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   cpd_req_if.sink   req,
   cpd_rsp_if.source rsp,
   cpd_csr_if.sink   csr
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam int CMP_W = (CNT_W > DEPTH_W) ? CNT_W : DEPTH_W;

   // Configuration registers.
   logic               trace_enable_ff;
   logic [DEPTH_W-1:0] depth_limit_ff;
   logic [TIME_W-1:0]  min_cost_ff;

   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         trace_enable_ff <= RST_TRACE_ENABLE;
         depth_limit_ff  <= RST_DEPTH_LIMIT;
         min_cost_ff     <= RST_MIN_COST;
      end else if (csr.valid) begin
         case (csr.index)
            REG_TRACE_ENABLE: trace_enable_ff <= csr.data[0];
            REG_DEPTH_LIMIT:  depth_limit_ff  <= csr.data[DEPTH_W-1:0];
            REG_MIN_COST:     min_cost_ff     <= csr.data[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Stack control.
   logic [CNT_W-1:0]   depth_ff, depth_in;
   logic [COUNT_W-1:0] ignored_ff, ignored_in;
   logic [CNT_W-1:0]   top_idx;
   logic               accept;
   logic               counted;
   logic               refuse;
   logic               ign_pending;
   stack_ctrl_type     ctrl;
   logic [TIME_W:0]    diff;
   logic [COST_W-1:0]  cost;
   logic               slow;
   logic               q_push;
   logic               q_not_full;
   record_type         rec;
   frame_type          new_frame;
   frame_type          cell_frame [STACK_DEPTH];

   assign req.ready   = q_not_full;
   assign accept      = req.valid && req.ready;
   assign counted     = accept && trace_enable_ff && req.on_main_thread;
   assign top_idx     = depth_ff - 1'b1;
   assign ign_pending = (ignored_ff != '0);

   // A push is refused above the depth limit or when every cell is occupied.
   assign refuse = (CMP_W'(depth_ff) > CMP_W'(depth_limit_ff)) ||
                   (depth_ff == CNT_W'(STACK_DEPTH));

   assign ctrl.push = counted && (req.kind == KIND_ENTER) && !refuse;
   assign ctrl.pop  = counted && (req.kind == KIND_RETURN) && !ign_pending &&
                      (depth_ff != '0);

   // The start time is below 2**30, so the 64-bit wrap is a sign extension.
   assign diff = {1'b0, req.timestamp} - {1'b0, cell_frame[0].start};
   assign cost = {{(COST_W - TIME_W - 1){diff[TIME_W]}}, diff};
   assign slow = diff[TIME_W] || (diff[TIME_W-1:0] >= min_cost_ff);

   assign q_push           = ctrl.pop && slow;
   assign rec.rec_class    = cell_frame[0].class_id;
   assign rec.rec_selector = cell_frame[0].selector_id;
   assign rec.rec_depth    = DEPTH_W'(top_idx);
   assign rec.rec_cost     = cost;

   always_comb begin
      depth_in   = depth_ff;
      ignored_in = ignored_ff;
      if (ctrl.push) begin
         depth_in = depth_ff + 1'b1;
      end else if (ctrl.pop) begin
         depth_in = depth_ff - 1'b1;
      end
      if (counted && (req.kind == KIND_ENTER) && refuse && !(&ignored_ff)) begin
         ignored_in = ignored_ff + 1'b1;
      end else if (counted && (req.kind == KIND_RETURN) && ign_pending) begin
         ignored_in = ignored_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff   <= '0;
         ignored_ff <= '0;
      end else begin
         depth_ff   <= depth_in;
         ignored_ff <= ignored_in;
      end
   end

   assign new_frame.class_id    = req.class_id;
   assign new_frame.selector_id = req.selector_id;
   assign new_frame.start       = req.timestamp;

   // Cell 0 holds the top of the stack.
   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      frame_type above;
      frame_type below;
      if (i == 0) begin : g_first
         assign above = new_frame;
      end else begin : g_rest
         assign above = cell_frame[i-1];
      end
      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = cell_frame[i];
      end else begin : g_inner
         assign below = cell_frame[i+1];
      end
      cpd_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .from_above (above),
         .from_below (below),
         .frame      (cell_frame[i])
      );
   end

   cpd_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (rec),
      .not_full  (q_not_full),
      .rsp       (rsp)
   );

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> depth_ff == $past(depth_ff) + 1'b1)
      else $error("push did not grow the stack");

   a_pop_shrinks: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |=> depth_ff == $past(depth_ff) - 1'b1)
      else $error("pop did not shrink the stack");

   a_pop_needs_no_ignored: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> (ignored_ff == '0) && (depth_ff != '0))
      else $error("pop while ignored calls pending or stack empty");

   a_record_shown: assert property (@(posedge clock) disable iff (reset)
      q_push |=> rsp.valid)
      else $error("record was not presented");

endmodule
